// ----- rtl/life_automaton_grid_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the life automaton grid
// Clocked implication checks used by life_automaton_grid.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LIFE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIFE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/life_pkg.sv -----
// ----------------------------------------------------------------------------
// life_pkg
// Types and constants shared by the life automaton grid modules.
// ----------------------------------------------------------------------------
`default_nettype none

package life_pkg;

    localparam int CMD_W = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;

    // B3/S23 rule constants.
    localparam int BIRTH_COUNT    = 3;
    localparam int SURVIVE_COUNT  = 2;
    localparam int NEIGHBOR_COUNT = 8;
    localparam int CNT_W          = $clog2(NEIGHBOR_COUNT + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_run;   // zero one row of the store
        logic latch;       // a transaction is accepted this cycle
        logic step_start;  // the accepted transaction is a generation step
        logic step_run;    // advance the generation sweep
        logic finish;      // push the result and commit a pending cell write
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic step_done;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/life_dp.sv -----
// ----------------------------------------------------------------------------
// life_dp
// Grid store, generation sweep with a three-row window, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module life_dp #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire life_pkg::ctrl_cmd_t         cmd,
    output      life_pkg::dp_status_t        status,
    input  wire logic [life_pkg::CMD_W-1:0]  s_command,
    input  wire logic [life_pkg::ROW_W-1:0]  s_row,
    input  wire logic [life_pkg::COL_W-1:0]  s_col,
    input  wire logic                        s_cell_in,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic                        m_cell_out
);
    import life_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int SW = $clog2(ROWS + 1);

    logic [COLS-1:0] store [ROWS];
    logic [COLS-1:0] rd_word_reg;

    logic [SW-1:0]   sweep_reg;
    logic            rvalid_reg;
    logic            have_mid_reg;
    logic [RW-1:0]   rrow_reg;
    logic [RW-1:0]   wrow_reg;
    logic [COLS-1:0] up_reg;
    logic [COLS-1:0] mid_reg;

    logic [CMD_W-1:0] cmd_reg;
    logic [RW-1:0]    addr_reg;
    logic [CW-1:0]    col_reg;
    logic             cell_reg;
    logic             inside_reg;

    logic            m_valid_reg;
    logic            m_cell_out_reg;

    logic [RW+ROW_W-1:0] row_wide;
    logic [CW+COL_W-1:0] col_wide;
    logic                inside_in;
    logic                sweep_more;

    logic            mem_we;
    logic [RW-1:0]   mem_waddr;
    logic [COLS-1:0] mem_wdata;
    logic            mem_re;
    logic [RW-1:0]   mem_raddr;

    logic [COLS-1:0] life_word;
    logic [COLS-1:0] merged_word;
    logic [COLS-1:0] bit_mask;

    assign row_wide   = (RW + ROW_W)'(s_row);
    assign col_wide   = (CW + COL_W)'(s_col);
    assign inside_in  = (32'(s_row) < ROWS) && (32'(s_col) < COLS);
    assign sweep_more = (sweep_reg != SW'(ROWS));

    // New generation for the row held in mid_reg. Past the last row the lower
    // neighbor row is all dead.
    always_comb begin
        logic [COLS+1:0]  up_pad;
        logic [COLS+1:0]  mid_pad;
        logic [COLS+1:0]  dn_pad;
        logic [CNT_W-1:0] cnt;
        up_pad  = {1'b0, up_reg, 1'b0};
        mid_pad = {1'b0, mid_reg, 1'b0};
        dn_pad  = rvalid_reg ? {1'b0, rd_word_reg, 1'b0} : '0;
        for (int c = 0; c < COLS; c++) begin
            cnt = CNT_W'(up_pad[c]) + CNT_W'(up_pad[c+1]) + CNT_W'(up_pad[c+2])
                + CNT_W'(mid_pad[c]) + CNT_W'(mid_pad[c+2])
                + CNT_W'(dn_pad[c]) + CNT_W'(dn_pad[c+1]) + CNT_W'(dn_pad[c+2]);
            life_word[c] = (cnt == CNT_W'(BIRTH_COUNT))
                || (mid_pad[c+1] && (cnt == CNT_W'(SURVIVE_COUNT)));
        end
    end

    assign bit_mask    = COLS'(1) << col_reg;
    assign merged_word = cell_reg ? (rd_word_reg | bit_mask) : (rd_word_reg & ~bit_mask);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg[RW-1:0];
        mem_wdata = '0;
        if (cmd.clear_run) begin
            mem_we = 1'b1;
        end else if (cmd.step_run) begin
            mem_we    = have_mid_reg;
            mem_waddr = wrow_reg;
            mem_wdata = life_word;
        end else if (cmd.finish) begin
            mem_we    = (cmd_reg == CMD_WRITE) && inside_reg;
            mem_waddr = addr_reg;
            mem_wdata = merged_word;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = sweep_reg[RW-1:0];
        if (cmd.step_run) begin
            mem_re = sweep_more;
        end else if (cmd.latch && !cmd.step_start) begin
            mem_re    = inside_in;
            mem_raddr = row_wide[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_word_reg <= store[mem_raddr];
        end
    end

    // Sweep control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg    <= '0;
            rvalid_reg   <= 1'b0;
            have_mid_reg <= 1'b0;
        end else if (cmd.step_start) begin
            sweep_reg    <= '0;
            rvalid_reg   <= 1'b0;
            have_mid_reg <= 1'b0;
        end else begin
            if (cmd.clear_run || (cmd.step_run && sweep_more)) begin
                sweep_reg <= sweep_reg + SW'(1);
            end
            rvalid_reg <= cmd.step_run && sweep_more;
            if (cmd.step_run) begin
                have_mid_reg <= rvalid_reg;
            end
        end
    end

    // Row window: up_reg is the old row above mid_reg. Both start dead so the
    // first row sees an all-dead row above it.
    always_ff @(posedge aclk) begin
        if (cmd.step_start) begin
            up_reg  <= '0;
            mid_reg <= '0;
        end else if (cmd.step_run && rvalid_reg) begin
            up_reg   <= mid_reg;
            mid_reg  <= rd_word_reg;
            wrow_reg <= rrow_reg;
        end
        if (mem_re) begin
            rrow_reg <= mem_raddr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_reg    <= s_command;
            addr_reg   <= row_wide[RW-1:0];
            col_reg    <= col_wide[CW-1:0];
            cell_reg   <= s_cell_in;
            inside_reg <= inside_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_cell_out_reg <= (cmd_reg == CMD_READ) && inside_reg && rd_word_reg[col_reg];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_out_reg;

    assign status.clear_last = (sweep_reg == SW'(ROWS - 1));
    assign status.step_done  = !sweep_more && !rvalid_reg && !have_mid_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

endmodule

`default_nettype wire

// ----- rtl/life_ctrl.sv -----
// ----------------------------------------------------------------------------
// life_ctrl
// Sequencer for the clearing pass, cell accesses and generation sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module life_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [life_pkg::CMD_W-1:0]  s_command,
    input  wire life_pkg::dp_status_t        status,
    output      life_pkg::ctrl_cmd_t         cmd
);
    import life_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_run = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.latch      = accept;
                cmd.step_start = accept && (s_command == CMD_STEP);
                if (accept) begin
                    state_next = (s_command == CMD_STEP) ? ST_STEP : ST_FINISH;
                end
            end
            ST_STEP: begin
                if (status.step_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.step_run = 1'b1;
                end
            end
            ST_FINISH: begin
                // Wait here while the result register is still held.
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/life_automaton_grid.sv -----
// ----------------------------------------------------------------------------
// life_automaton_grid
// ROWS by COLS grid of one-bit cells with write, read and B3/S23 step commands.
// ----------------------------------------------------------------------------
//   Channel | Ports                                     | Direction
//   --------+-------------------------------------------+----------
//   command | s_valid s_ready s_command s_row s_col     | in
//           | s_cell_in                                 |
//   result  | m_valid m_ready m_cell_out                | out
//
// After acceptance a write, read or unused command goes to the finish state, then its result is registered for output.
// A generation step sweeps the store with one store row read per cycle, then presents its result.
// The next command can be taken in the cycle after the result is pushed.
// After reset a clearing pass zeroes the store, one row per cycle;
// no command is accepted until it ends.
// A stalled result waits in the output register; a following command is taken
// but holds its result, and no further command is accepted, until it frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_automaton_grid_assert.svh"

module life_automaton_grid #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [life_pkg::CMD_W-1:0]  s_command,
    input  wire logic [life_pkg::ROW_W-1:0]  s_row,
    input  wire logic [life_pkg::COL_W-1:0]  s_col,
    input  wire logic                        s_cell_in,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic                        m_cell_out
);
    import life_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    life_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .cmd       (cmd)
    );

    life_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_command  (s_command),
        .s_row      (s_row),
        .s_col      (s_col),
        .s_cell_in  (s_cell_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out)
    );

    `LIFE_ASSERT_SAME(a_no_accept_in_clear, aclk, aresetn, cmd.clear_run, !s_ready, "transaction accepted during clearing pass")
    `LIFE_ASSERT_SAME(a_finish_needs_slot, aclk, aresetn, cmd.finish, !status.out_busy, "result pushed into a held output register")
    `LIFE_ASSERT_NEXT(a_finish_shows_result, aclk, aresetn, cmd.finish, m_valid, "pushed result not presented")
    `LIFE_ASSERT_SAME(a_step_only_on_accept, aclk, aresetn, cmd.step_start || cmd.latch, s_valid && s_ready, "datapath latched without a transaction")

endmodule

`default_nettype wire
